FILE: hw/rtl/mlp_sigmoid_classifier_defines.svh
// assertion macros for the two-layer perceptron classifier
`ifndef MLP_SIGMOID_CLASSIFIER_DEFINES_SVH
`define MLP_SIGMOID_CLASSIFIER_DEFINES_SVH
`ifndef SYNTH
`define MSC_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication check failed");
`define MSC_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle check failed");
`else
`define MSC_ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define MSC_ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

FILE: hw/rtl/msc_pkg.sv
// constants, opcodes and the sigmoid table for the perceptron classifier
package msc_pkg;

    localparam int INPUT_COUNT         = 8;
    localparam int HIDDEN_COUNT        = 8;
    localparam int SIGMOID_TABLE_DEPTH = 1024;
    localparam int TABLE_ADDR_W        = $clog2(SIGMOID_TABLE_DEPTH);

    localparam int W2_BASE     = INPUT_COUNT * HIDDEN_COUNT;
    localparam int B1_BASE     = W2_BASE + HIDDEN_COUNT;
    localparam int B2_AT       = B1_BASE + HIDDEN_COUNT;
    localparam int PARAM_COUNT = B2_AT + 1;
    localparam int STORE_ADDR_W = $clog2(PARAM_COUNT);

    localparam int FEATURE_W = 20;
    localparam int PARAM_W   = 16;
    localparam int LEVEL_W   = 16;
    localparam int INDEX_W   = 7;

    // opcodes
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_CLASSIFY = 1'b1;

    localparam logic [63:0] ONE_Q30           = 64'd1 << 30;
    localparam logic [63:0] EXP_MINUS_ONE_Q30 = 64'd395007542;
    localparam int          TAYLOR_TERMS      = 14;

    typedef logic [LEVEL_W-1:0] sig_table_t [SIGMOID_TABLE_DEPTH];

    // shift-and-subtract quotient, valid when the quotient fits in qbits bits
    function automatic logic [63:0] div_bits(input logic [63:0] num,
                                             input logic [63:0] den,
                                             input int qbits);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = num;
        quo = 64'd0;
        for (int i = qbits - 1; i >= 0; i--)
        begin
            if (rem >= (den << i))
            begin
                rem    = rem - (den << i);
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // sigmoid of a non-negative q16 magnitude, q0.16, not capped
    function automatic logic [63:0] sig_nonneg(input logic [63:0] t);
        logic [63:0] whole;
        logic [63:0] frac;
        logic [63:0] term;
        logic [63:0] e;
        logic [63:0] d;
        longint      sum;
        whole = t >> 16;
        frac  = t & 64'hFFFF;
        term  = ONE_Q30;
        sum   = longint'(ONE_Q30);
        for (int k = 1; k <= TAYLOR_TERMS; k++)
        begin
            // term * frac stays below 2^46, so the scaled value fits in 30 bits
            term = div_bits((term * frac) >> 16, 64'(k), 30);
            if (k[0])
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        e = (sum < 0) ? 64'd0 : 64'(sum);
        for (int k = 0; k < 64; k++)
        begin
            if (64'(k) < whole)
                e = (e * EXP_MINUS_ONE_Q30) >> 30;
        end
        d = ONE_Q30 + e;
        return div_bits((64'd1 << 46) + (d >> 1), d, 17);
    endfunction

    // each entry holds the sigmoid at the center of its interval over [-8, 8)
    function automatic sig_table_t build_sig_table();
        sig_table_t  tbl;
        longint      c;
        logic [63:0] s;
        for (int i = 0; i < SIGMOID_TABLE_DEPTH; i++)
        begin
            c = (((2 * longint'(i) + 1) * (longint'(1) << 19)) >>> TABLE_ADDR_W)
                - (longint'(1) << 19);
            if (c >= 0)
            begin
                s = sig_nonneg(64'(c));
                if (s > 64'd65535)
                    s = 64'd65535;
            end
            else
            begin
                s = 64'd65536 - sig_nonneg(64'(-c));
            end
            tbl[i] = s[LEVEL_W-1:0];
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

FILE: hw/rtl/mlp_sigmoid_classifier.sv
// two-layer perceptron classifier with sigmoid table, eight-stage pipeline
//
// One input channel (in_valid/in_ready) carries load and classify items.
// A load writes one signed q8.8 word into the parameter store and gives no
// result; a classify runs 8 features through 8 hidden units and one output
// unit and gives one result on the output channel (out_valid/out_ready).
// A classify passes through multiply, hidden sum, saturate/index, table
// read, multiply, output sum, saturate/index and a table read into the
// output register; out_valid marks the result there.
// A classify can be taken every cycle while the output is not stalled. A
// load is held off while any classify is still in the first seven stages,
// since the pipeline reads the store directly.
// Reset clears all valid bits; the parameter store is undefined until
// each word is loaded. When the receiver stalls, the whole pipeline
// freezes and in_ready drops, so nothing is lost or repeated.
// Load indexes past the end of the store are dropped.
`include "mlp_sigmoid_classifier_defines.svh"
module mlp_sigmoid_classifier
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [6:0]  param_index,
    input  logic signed [15:0] param_value,
    input  logic signed [19:0] feature_0,
    input  logic signed [19:0] feature_1,
    input  logic signed [19:0] feature_2,
    input  logic signed [19:0] feature_3,
    input  logic signed [19:0] feature_4,
    input  logic signed [19:0] feature_5,
    input  logic signed [19:0] feature_6,
    input  logic signed [19:0] feature_7,
    input  logic        label,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        predicted_class,
    output logic [15:0] output_level,
    output logic        label_match
);

    localparam int NI     = msc_pkg::INPUT_COUNT;
    localparam int NH     = msc_pkg::HIDDEN_COUNT;
    localparam int TW     = msc_pkg::TABLE_ADDR_W;
    localparam int STAGES = 8;
    localparam int PROD1_W = msc_pkg::FEATURE_W + msc_pkg::PARAM_W;
    localparam int ACC1_W  = PROD1_W + $clog2(NI + 1);
    localparam int PROD2_W = msc_pkg::LEVEL_W + 1 + msc_pkg::PARAM_W;
    localparam int ACC2_W  = PROD2_W + $clog2(NH + 1);
    localparam int SPAN1   = 16 + 4;
    localparam int SPAN2   = 24 + 4;
    localparam logic signed [ACC1_W-1:0] LO1 = -(ACC1_W'(1) <<< (SPAN1 - 1));
    localparam logic signed [ACC1_W-1:0] HI1 = (ACC1_W'(1) <<< (SPAN1 - 1)) - 1;
    localparam logic signed [ACC2_W-1:0] LO2 = -(ACC2_W'(1) <<< (SPAN2 - 1));
    localparam logic signed [ACC2_W-1:0] HI2 = (ACC2_W'(1) <<< (SPAN2 - 1)) - 1;

    logic signed [msc_pkg::PARAM_W-1:0] store_reg [msc_pkg::PARAM_COUNT];

    logic [STAGES-1:0] valid_reg;
    logic [STAGES-1:0] valid_next;
    logic [STAGES-1:0] lab_reg;

    logic signed [PROD1_W-1:0] prod1_reg [NH][NI];
    logic signed [ACC1_W-1:0]  acc1_reg [NH];
    logic [TW-1:0]             idx1_reg [NH];
    logic [msc_pkg::LEVEL_W-1:0] hid_reg [NH];
    logic signed [PROD2_W-1:0] prod2_reg [NH];
    logic signed [ACC2_W-1:0]  acc2_reg;
    logic [TW-1:0]             idx2_reg;
    logic [msc_pkg::LEVEL_W-1:0] level_reg;

    logic signed [msc_pkg::FEATURE_W-1:0] feat [NI];
    logic signed [ACC1_W-1:0] acc1_next [NH];
    logic signed [ACC1_W-1:0] sat1 [NH];
    logic signed [ACC2_W-1:0] acc2_next;
    logic signed [ACC2_W-1:0] sat2;
    logic en;
    logic busy;
    logic in_xfer;
    logic load_xfer;

    // pipeline advances whenever the output register is free or drains
    assign en        = !valid_reg[STAGES-1] || out_ready;
    assign busy      = |valid_reg[STAGES-2:0];
    assign in_ready  = en && (opcode == msc_pkg::OP_CLASSIFY || !busy);
    assign in_xfer   = in_valid && in_ready;
    assign load_xfer = in_xfer && opcode == msc_pkg::OP_LOAD;

    assign feat[0] = feature_0;
    assign feat[1] = feature_1;
    assign feat[2] = feature_2;
    assign feat[3] = feature_3;
    assign feat[4] = feature_4;
    assign feat[5] = feature_5;
    assign feat[6] = feature_6;
    assign feat[7] = feature_7;

    // parameter store write
    always_ff @(posedge clk)
    begin
        if (load_xfer && {25'd0, param_index} < 32'(msc_pkg::PARAM_COUNT))
        begin
            store_reg[param_index[msc_pkg::STORE_ADDR_W-1:0]] <= param_value;
        end
    end

    // valid bits
    always_comb
    begin
        valid_next = {valid_reg[STAGES-2:0], in_xfer && opcode == msc_pkg::OP_CLASSIFY};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    // hidden sums and saturation
    always_comb
    begin
        for (int k = 0; k < NH; k++)
        begin
            acc1_next[k] = ACC1_W'(store_reg[msc_pkg::B1_BASE + k]) <<< 8;
            for (int j = 0; j < NI; j++)
            begin
                acc1_next[k] = acc1_next[k] + ACC1_W'(prod1_reg[k][j]);
            end
            sat1[k] = (acc1_reg[k] < LO1) ? LO1 : (acc1_reg[k] > HI1) ? HI1 : acc1_reg[k];
        end
    end

    // output sum and saturation
    always_comb
    begin
        acc2_next = ACC2_W'(store_reg[msc_pkg::B2_AT]) <<< 16;
        for (int k = 0; k < NH; k++)
        begin
            acc2_next = acc2_next + ACC2_W'(prod2_reg[k]);
        end
        sat2 = (acc2_reg < LO2) ? LO2 : (acc2_reg > HI2) ? HI2 : acc2_reg;
    end

    // datapath stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lab_reg <= {lab_reg[STAGES-2:0], label};
            for (int k = 0; k < NH; k++)
            begin
                for (int j = 0; j < NI; j++)
                begin
                    prod1_reg[k][j] <= PROD1_W'(feat[j])
                                       * PROD1_W'(store_reg[j * NH + k]);
                end
                acc1_reg[k]  <= acc1_next[k];
                idx1_reg[k]  <= {~sat1[k][SPAN1-1], sat1[k][SPAN1-2 -: TW-1]};
                hid_reg[k]   <= msc_pkg::SIG_TABLE[idx1_reg[k]];
                prod2_reg[k] <= $signed({1'b0, hid_reg[k]})
                                * PROD2_W'(store_reg[msc_pkg::W2_BASE + k]);
            end
            acc2_reg  <= acc2_next;
            idx2_reg  <= {~sat2[SPAN2-1], sat2[SPAN2-2 -: TW-1]};
            level_reg <= msc_pkg::SIG_TABLE[idx2_reg];
        end
    end

    assign out_valid       = valid_reg[STAGES-1];
    assign output_level    = level_reg;
    assign predicted_class = level_reg[msc_pkg::LEVEL_W-1];
    assign label_match     = level_reg[msc_pkg::LEVEL_W-1] == lab_reg[STAGES-1];

    // checks
    `MSC_ASSERT_IMPLY(a_load_idle, clk, rst_n, load_xfer, !busy)
    `MSC_ASSERT_NEXT(a_classify_enters, clk, rst_n,
        in_xfer && opcode == msc_pkg::OP_CLASSIFY, valid_reg[0])
    `MSC_ASSERT_NEXT(a_stall_freezes, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(valid_reg))

endmodule

FILE: tb/mlp_sigmoid_classifier_tb.sv
// self-checking testbench for the two-layer perceptron classifier
module mlp_sigmoid_classifier_tb;

    typedef struct packed {
        logic        cls;
        logic [15:0] level;
        logic        match;
    } verdict_t;

    typedef struct {
        logic               op;
        logic [6:0]         idx;
        logic signed [15:0] val;
        logic signed [19:0] feat [msc_pkg::INPUT_COUNT];
        logic               lab;
        logic               has_exp;
        verdict_t           exp_v;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic opcode;
    logic [6:0] param_index;
    logic signed [15:0] param_value;
    logic signed [19:0] feature_0, feature_1, feature_2, feature_3;
    logic signed [19:0] feature_4, feature_5, feature_6, feature_7;
    logic label;
    logic out_valid;
    logic out_ready;
    logic predicted_class;
    logic [15:0] output_level;
    logic label_match;

    // model state of the parameter store and the sigmoid table
    logic [15:0] weight_mem [msc_pkg::PARAM_COUNT];
    logic [15:0] sig_lut [msc_pkg::SIGMOID_TABLE_DEPTH];
    verdict_t    pending_verdicts [$];
    int          fail_count;
    int          sample_count;
    int          load_count;
    int          stall_left;
    bit          calm;

    mlp_sigmoid_classifier u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .param_index(param_index), .param_value(param_value),
        .feature_0(feature_0), .feature_1(feature_1), .feature_2(feature_2),
        .feature_3(feature_3), .feature_4(feature_4), .feature_5(feature_5),
        .feature_6(feature_6), .feature_7(feature_7), .label(label),
        .out_valid(out_valid), .out_ready(out_ready),
        .predicted_class(predicted_class), .output_level(output_level),
        .label_match(label_match)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #100000000;
        $display("CHECK FAILED");
        $finish;
    end

    // sigmoid of non-negative q16 magnitude
    function automatic longint unsigned sig_pos(longint unsigned t);
        longint unsigned whole, frac, term, e, d;
        longint sum;
        whole = t >> 16;
        frac = t & 64'hFFFF;
        term = 64'd1 << 30;
        sum = longint'(64'd1 << 30);
        for (int k = 1; k <= 14; k++)
        begin
            term = (term * frac) / (longint'(k) * 65536);
            if (k % 2 == 1)
                sum -= longint'(term);
            else
                sum += longint'(term);
        end
        e = (sum < 0) ? 0 : longint'(sum);
        for (longint unsigned k = 0; k < whole && k < 64; k++)
            e = (e * 64'd395007542) >> 30;
        d = (64'd1 << 30) + e;
        return ((64'd1 << 46) + d / 2) / d;
    endfunction

    function automatic void fill_lut();
        longint c;
        longint unsigned s;
        for (int i = 0; i < msc_pkg::SIGMOID_TABLE_DEPTH; i++)
        begin
            c = ((2 * longint'(i) + 1) * (longint'(1) << 19)) / msc_pkg::SIGMOID_TABLE_DEPTH
                - (longint'(1) << 19);
            if (c >= 0)
            begin
                s = sig_pos(c);
                if (s > 65535)
                    s = 65535;
            end
            else
            begin
                s = 65536 - sig_pos(-c);
            end
            sig_lut[i] = s[15:0];
        end
    endfunction

    // saturate to [-8, 8) and look up
    function automatic logic [15:0] squash(longint acc, int fb);
        longint lo, hi;
        longint unsigned ix;
        lo = -(longint'(8) <<< fb);
        hi = (longint'(8) <<< fb) - 1;
        if (acc < lo)
            acc = lo;
        if (acc > hi)
            acc = hi;
        ix = (longint'(acc - lo) * msc_pkg::SIGMOID_TABLE_DEPTH) >> (fb + 4);
        if (ix >= msc_pkg::SIGMOID_TABLE_DEPTH)
            ix = msc_pkg::SIGMOID_TABLE_DEPTH - 1;
        return sig_lut[ix];
    endfunction

    // forward pass of one sample on the current store
    function automatic verdict_t classify_sample(row_t r);
        verdict_t v;
        logic [15:0] hid [msc_pkg::HIDDEN_COUNT];
        longint acc;
        for (int k = 0; k < msc_pkg::HIDDEN_COUNT; k++)
        begin
            acc = longint'($signed(weight_mem[msc_pkg::B1_BASE + k])) * 256;
            for (int j = 0; j < msc_pkg::INPUT_COUNT; j++)
                acc += longint'(r.feat[j]) *
                       longint'($signed(weight_mem[j * msc_pkg::HIDDEN_COUNT + k]));
            hid[k] = squash(acc, 16);
        end
        acc = longint'($signed(weight_mem[msc_pkg::B2_AT])) * 65536;
        for (int k = 0; k < msc_pkg::HIDDEN_COUNT; k++)
            acc += longint'({48'd0, hid[k]}) *
                   longint'($signed(weight_mem[msc_pkg::W2_BASE + k]));
        v.level = squash(acc, 24);
        v.cls = (v.level >= 16'd32768);
        v.match = (v.cls == r.lab);
        return v;
    endfunction

    // random input gap with valid low
    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    // drive one item and hold it until the transfer
    task automatic send_item(row_t r);
        verdict_t v;
        idle_gap();
        opcode <= r.op;
        param_index <= r.idx;
        param_value <= r.val;
        feature_0 <= r.feat[0];
        feature_1 <= r.feat[1];
        feature_2 <= r.feat[2];
        feature_3 <= r.feat[3];
        feature_4 <= r.feat[4];
        feature_5 <= r.feat[5];
        feature_6 <= r.feat[6];
        feature_7 <= r.feat[7];
        label <= r.lab;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (r.op == msc_pkg::OP_LOAD)
        begin
            if (r.idx < msc_pkg::PARAM_COUNT)
                weight_mem[r.idx] = r.val;
            load_count++;
        end
        else
        begin
            v = classify_sample(r);
            if (r.has_exp)
                pending_verdicts.insert(pending_verdicts.size(), r.exp_v);
            else
                pending_verdicts.insert(pending_verdicts.size(), v);
            sample_count++;
        end
        @(negedge clk);
    endtask

    function automatic row_t load_row(int idx, int val);
        row_t r;
        r.op = msc_pkg::OP_LOAD;
        r.idx = idx[6:0];
        r.val = val[15:0];
        for (int j = 0; j < msc_pkg::INPUT_COUNT; j++)
            r.feat[j] = 20'($urandom);
        r.lab = 1'($urandom);
        r.has_exp = 0;
        r.exp_v = '0;
        return r;
    endfunction

    function automatic row_t sample_row(int f, bit lab);
        row_t r;
        r.op = msc_pkg::OP_CLASSIFY;
        r.idx = 7'($urandom);
        r.val = 16'($urandom);
        for (int j = 0; j < msc_pkg::INPUT_COUNT; j++)
            r.feat[j] = f[19:0];
        r.lab = lab;
        r.has_exp = 0;
        r.exp_v = '0;
        return r;
    endfunction

    function automatic row_t rand_sample();
        row_t r;
        r = sample_row(0, 1'($urandom));
        for (int j = 0; j < msc_pkg::INPUT_COUNT; j++)
        begin
            case ($urandom_range(0, 3))
                0: r.feat[j] = 20'($urandom);
                1: r.feat[j] = 20'($signed($urandom_range(0, 4095)) - 2048);
                2: r.feat[j] = $urandom_range(0, 1) ? 20'h7FFFF : 20'h80000;
                default: r.feat[j] = 20'($signed($urandom_range(0, 511)) - 256);
            endcase
        end
        return r;
    endfunction

    // output side: random stall bursts and compare
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            stall_left = 0;
            out_ready <= 1'b0;
        end
        else if (calm)
            out_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $error("result transfer with nothing expected");
                fail_count++;
            end
            else
            begin
                want = pending_verdicts.pop_front();
                if (predicted_class !== want.cls)
                begin
                    $error("predicted_class expected %0d actual %0d", want.cls,
                           predicted_class);
                    fail_count++;
                end
                if (output_level !== want.level)
                begin
                    $error("output_level expected %0d actual %0d", want.level,
                           output_level);
                    fail_count++;
                end
                if (label_match !== want.match)
                begin
                    $error("label_match expected %0d actual %0d", want.match,
                           label_match);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        row_t dir_rows [$];
        row_t r;
        int wait_cycles;
        fail_count = 0;
        sample_count = 0;
        load_count = 0;
        stall_left = 0;
        calm = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = msc_pkg::OP_LOAD;
        param_index = '0;
        param_value = '0;
        {feature_0, feature_1, feature_2, feature_3} = '0;
        {feature_4, feature_5, feature_6, feature_7} = '0;
        label = 1'b0;
        for (int i = 0; i < msc_pkg::PARAM_COUNT; i++)
            weight_mem[i] = '0;
        fill_lut();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table: zero store, then extremes
        for (int i = 0; i < msc_pkg::PARAM_COUNT; i++)
            send_item(load_row(i, 0));
        r = sample_row(0, 1'b1);
        r.has_exp = 1;
        r.exp_v = '{cls: 1'b1, level: sig_lut[msc_pkg::SIGMOID_TABLE_DEPTH / 2], match: 1'b1};
        dir_rows.insert(dir_rows.size(), r);
        r = sample_row(0, 1'b0);
        r.has_exp = 1;
        r.exp_v = '{cls: 1'b1, level: sig_lut[msc_pkg::SIGMOID_TABLE_DEPTH / 2], match: 1'b0};
        dir_rows.insert(dir_rows.size(), r);
        // output bias extremes saturate the output unit
        dir_rows.insert(dir_rows.size(), load_row(msc_pkg::B2_AT, 32767));
        r = sample_row(0, 1'b1);
        r.has_exp = 1;
        r.exp_v = '{cls: 1'b1, level: sig_lut[msc_pkg::SIGMOID_TABLE_DEPTH - 1],
                    match: 1'b1};
        dir_rows.insert(dir_rows.size(), r);
        dir_rows.insert(dir_rows.size(), load_row(msc_pkg::B2_AT, -32768));
        r = sample_row(0, 1'b1);
        r.has_exp = 1;
        r.exp_v = '{cls: 1'b0, level: sig_lut[0], match: 1'b0};
        dir_rows.insert(dir_rows.size(), r);
        // out-of-range load is dropped
        dir_rows.insert(dir_rows.size(), load_row(127, 12345));
        dir_rows.insert(dir_rows.size(), load_row(msc_pkg::PARAM_COUNT, -1));
        dir_rows.insert(dir_rows.size(), load_row(0, 32767));
        dir_rows.insert(dir_rows.size(), load_row(msc_pkg::W2_BASE, -32768));
        dir_rows.insert(dir_rows.size(), load_row(msc_pkg::B1_BASE, 32767));
        dir_rows.insert(dir_rows.size(), sample_row(524287, 1'b1));
        dir_rows.insert(dir_rows.size(), sample_row(-524288, 1'b0));
        dir_rows.insert(dir_rows.size(), sample_row(-1, 1'b1));
        dir_rows.insert(dir_rows.size(), sample_row(1, 1'b0));
        foreach (dir_rows[i])
            send_item(dir_rows[i]);

        // random part: mostly samples, with reloads of random words at random indices
        for (int n = 0; n < 1200; n++)
        begin
            if (n > 1080)
                calm = 1;
            if ($urandom_range(0, 9) < 3)
            begin
                case ($urandom_range(0, 3))
                    0: r = load_row($urandom_range(0, 127), $urandom);
                    1: r = load_row($urandom_range(0, msc_pkg::PARAM_COUNT - 1),
                                    $signed($urandom_range(0, 1023)) - 512);
                    default: r = load_row($urandom_range(0, msc_pkg::PARAM_COUNT - 1),
                                          $urandom);
                endcase
            end
            else
            begin
                r = rand_sample();
            end
            send_item(r);
        end
        in_valid <= 1'b0;

        // drain
        wait_cycles = 0;
        while (pending_verdicts.size() != 0 && wait_cycles < 100000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $error("%0d results never arrived", pending_verdicts.size());
            fail_count++;
        end
        $display("covered %0d parameter loads and %0d classified samples",
                 load_count, sample_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
